>>> hw/rtl/ptc_pkg.sv
// Package with widths, calibration defaults, register indexes and types for the compensation block.
package ptc_pkg;

	localparam int RAW_W     = 24;
	localparam int CAL_W     = 16;
	localparam int OUT_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int NSTG      = 10;

	localparam int DT_W    = RAW_W + 1;
	localparam int TM_W    = 19;
	localparam int TEMP_W  = 20;
	localparam int T2_W    = 18;
	localparam int SQ_W    = 34;
	localparam int OFF_W   = 40;
	localparam int OFF2_W  = 39;
	localparam int SENS2_W = 38;
	localparam int LO_W    = 20;
	localparam int HI_W    = OFF_W - LO_W;
	localparam int PROD_W  = 65;
	localparam int DIFF_W  = 45;

	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE    = 3'd5;

	localparam logic [CAL_W-1:0] RST_SENSITIVITY   = 16'd46372;
	localparam logic [CAL_W-1:0] RST_OFFSET        = 16'd43981;
	localparam logic [CAL_W-1:0] RST_SENS_TEMPCO   = 16'd29059;
	localparam logic [CAL_W-1:0] RST_OFFSET_TEMPCO = 16'd27842;
	localparam logic [CAL_W-1:0] RST_REF_TEMP      = 16'd31553;
	localparam logic [CAL_W-1:0] RST_TEMP_SLOPE    = 16'd28165;

	localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] DEEP_BIAS = 20'sd3500;
	localparam logic signed [TM_W-1:0]   TM_DEEP   = -19'sd3500;

	typedef struct packed {
		logic [CAL_W-1:0] sensitivity;
		logic [CAL_W-1:0] offset;
		logic [CAL_W-1:0] sens_tempco;
		logic [CAL_W-1:0] offset_tempco;
		logic [CAL_W-1:0] ref_temp;
		logic [CAL_W-1:0] temp_slope;
	} cal_t;

	localparam cal_t CAL_RESET = '{
		sensitivity:   RST_SENSITIVITY,
		offset:        RST_OFFSET,
		sens_tempco:   RST_SENS_TEMPCO,
		offset_tempco: RST_OFFSET_TEMPCO,
		ref_temp:      RST_REF_TEMP,
		temp_slope:    RST_TEMP_SLOPE
	};

endpackage

>>> hw/rtl/pressure_temperature_compensation.sv
// Ten-stage pipelined second-order pressure and temperature compensation.
//
//   Channel   Direction  Content
//   s_axis    in         raw pressure and raw temperature pair
//   m_axis    out        compensated pressure and temperature
//   cfg       in         calibration word write, index 0 to 5
//
// One pair enters per cycle unless the full pipeline is held by m_axis_tready low. Each result
// passes through the ten register stages: temperature difference, products, squares, corrections,
// the split 24 by 40 bit pressure multiply, its sum, the offset subtract and the final shift.
// Reset clears the stage valid bits and loads the default calibration words.
// Each stage holds while the one after it is full and stalled, so bubbles close up.
module pressure_temperature_compensation
	import ptc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [2*RAW_W-1:0]   s_axis_tdata,  // raw_pressure[23:0], raw_temperature[47:24]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [2*OUT_W-1:0]   m_axis_tdata,  // pressure_out[31:0], temperature_out[63:32]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_data
);

	cal_t cal_q;

	logic [NSTG:1] vld_q;
	logic [NSTG:1] adv;
	logic [NSTG:1] vld_in;

	// Stage 1
	logic [RAW_W-1:0]       d1_s1;
	logic signed [DT_W-1:0] dt_s1;
	// Stage 2
	logic [RAW_W-1:0]         d1_s2;
	logic signed [41:0]       slope_prod_s2;
	logic signed [41:0]       off_prod_s2;
	logic signed [41:0]       sens_prod_s2;
	logic signed [49:0]       dt_sq_s2;
	// Stage 3
	logic [RAW_W-1:0]          d1_s3;
	logic signed [TM_W-1:0]    tm_s3;
	logic signed [TEMP_W-1:0]  tp_s3;
	logic signed [OFF_W-1:0]   off1_s3;
	logic signed [OFF_W-1:0]   sens1_s3;
	logic [T2_W-1:0]           t2_s3;
	logic                      cold_s3;
	logic                      deep_s3;
	// Stage 4
	logic [RAW_W-1:0]          d1_s4;
	logic signed [TM_W-1:0]    tm_s4;
	logic [SQ_W-1:0]           tm2_s4;
	logic [SQ_W-1:0]           tp2_s4;
	logic signed [OFF_W-1:0]   off1_s4;
	logic signed [OFF_W-1:0]   sens1_s4;
	logic [T2_W-1:0]           t2_s4;
	logic                      cold_s4;
	logic                      deep_s4;
	// Stage 5
	logic [RAW_W-1:0]          d1_s5;
	logic signed [TEMP_W-1:0]  temp_s5;
	logic signed [OFF_W-1:0]   off1_s5;
	logic signed [OFF_W-1:0]   sens1_s5;
	logic [OFF2_W-1:0]         off2_s5;
	logic [SENS2_W-1:0]        sens2_s5;
	// Stage 6
	logic [RAW_W-1:0]          d1_s6;
	logic signed [TEMP_W-1:0]  temp_s6;
	logic signed [OFF_W-1:0]   off_s6;
	logic signed [OFF_W-1:0]   sens_s6;
	// Stage 7
	logic signed [TEMP_W-1:0]  temp_s7;
	logic signed [OFF_W-1:0]   off_s7;
	logic [RAW_W+LO_W-1:0]     lo_s7;
	logic signed [RAW_W+HI_W:0] hi_s7;
	// Stage 8
	logic signed [TEMP_W-1:0]  temp_s8;
	logic signed [OFF_W-1:0]   off_s8;
	logic signed [PROD_W-1:0]  prod_s8;
	// Stage 9
	logic signed [TEMP_W-1:0]  temp_s9;
	logic signed [DIFF_W-1:0]  diff_s9;
	// Stage 10
	logic signed [OUT_W-1:0]   pres_s10;
	logic signed [OUT_W-1:0]   temp_s10;

	// Combinational intermediates
	logic signed [DT_W-1:0]    dt_c;
	logic signed [TM_W-1:0]    tm_c;
	logic signed [37:0]        tm_sq_c;
	logic signed [39:0]        tp_sq_c;
	logic [39:0]               m61_c;
	logic [37:0]               tp15_c;
	logic [OFF2_W-1:0]         off2_c;
	logic [SENS2_W-1:0]        sens2_c;
	logic signed [TEMP_W-1:0]  t2_sub_c;

	// Calibration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= CAL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SENSITIVITY:   cal_q.sensitivity   <= cfg_data;
				REG_OFFSET:        cal_q.offset        <= cfg_data;
				REG_SENS_TEMPCO:   cal_q.sens_tempco   <= cfg_data;
				REG_OFFSET_TEMPCO: cal_q.offset_tempco <= cfg_data;
				REG_REF_TEMP:      cal_q.ref_temp      <= cfg_data;
				REG_TEMP_SLOPE:    cal_q.temp_slope    <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when its content moves on.
	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign vld_in        = {vld_q[NSTG-1:1], s_axis_tvalid};
	assign s_axis_tready = adv[1];
	assign m_axis_tvalid = vld_q[NSTG];
	assign m_axis_tdata  = {temp_s10, pres_s10};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// Stage 1: temperature difference.
	assign dt_c = $signed({1'b0, s_axis_tdata[2*RAW_W-1:RAW_W]})
		- $signed({1'b0, cal_q.ref_temp, 8'b0});

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			d1_s1 <= s_axis_tdata[RAW_W-1:0];
			dt_s1 <= dt_c;
		end
	end

	// Stage 2: first-order products and the square of the difference.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			d1_s2         <= d1_s1;
			slope_prod_s2 <= dt_s1 * $signed({1'b0, cal_q.temp_slope});
			off_prod_s2   <= dt_s1 * $signed({1'b0, cal_q.offset_tempco});
			sens_prod_s2  <= dt_s1 * $signed({1'b0, cal_q.sens_tempco});
			dt_sq_s2      <= dt_s1 * dt_s1;
		end
	end

	// Stage 3: first-order offset and sensitivity, temperature deviation from 20.00 C.
	assign tm_c = $signed(slope_prod_s2[41:23]);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			d1_s3    <= d1_s2;
			tm_s3    <= tm_c;
			tp_s3    <= TEMP_W'(tm_c) + DEEP_BIAS;
			off1_s3  <= $signed({7'b0, cal_q.offset, 17'b0})
				+ OFF_W'($signed(off_prod_s2[41:6]));
			sens1_s3 <= $signed({8'b0, cal_q.sensitivity, 16'b0})
				+ OFF_W'($signed(sens_prod_s2[41:7]));
			t2_s3    <= dt_sq_s2[48:31];
			cold_s3  <= tm_c[TM_W-1];
			deep_s3  <= tm_c < TM_DEEP;
		end
	end

	// Stage 4: squares for the low-temperature corrections.
	assign tm_sq_c = tm_s3 * tm_s3;
	assign tp_sq_c = tp_s3 * tp_s3;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			d1_s4    <= d1_s3;
			tm_s4    <= tm_s3;
			tm2_s4   <= tm_sq_c[SQ_W-1:0];
			tp2_s4   <= tp_sq_c[SQ_W-1:0];
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			t2_s4    <= t2_s3;
			cold_s4  <= cold_s3;
			deep_s4  <= deep_s3;
		end
	end

	// Stage 5: second-order corrections and the final temperature.
	assign m61_c    = {6'b0, tm2_s4} * 40'd61;
	assign tp15_c   = {4'b0, tp2_s4} * 38'd15;
	assign off2_c   = OFF2_W'(m61_c[39:4]) + (deep_s4 ? OFF2_W'(tp15_c) : '0);
	assign sens2_c  = SENS2_W'({tm2_s4, 1'b0})
		+ (deep_s4 ? SENS2_W'({tp2_s4, 3'b0}) : '0);
	assign t2_sub_c = cold_s4 ? $signed({2'b0, t2_s4}) : 20'sd0;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			d1_s5    <= d1_s4;
			temp_s5  <= TEMP_W'(tm_s4) + TEMP_BASE - t2_sub_c;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			off2_s5  <= cold_s4 ? off2_c : '0;
			sens2_s5 <= cold_s4 ? sens2_c : '0;
		end
	end

	// Stage 6: corrected offset and sensitivity.
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			d1_s6   <= d1_s5;
			temp_s6 <= temp_s5;
			off_s6  <= off1_s5 - $signed({1'b0, off2_s5});
			sens_s6 <= sens1_s5 - $signed({2'b0, sens2_s5});
		end
	end

	// Stage 7: raw pressure times sensitivity as two partial products.
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			temp_s7 <= temp_s6;
			off_s7  <= off_s6;
			lo_s7   <= d1_s6 * sens_s6[LO_W-1:0];
			hi_s7   <= $signed({1'b0, d1_s6}) * $signed(sens_s6[OFF_W-1:LO_W]);
		end
	end

	// Stage 8: full product.
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			temp_s8 <= temp_s7;
			off_s8  <= off_s7;
			prod_s8 <= (PROD_W'(hi_s7) <<< LO_W) + $signed({21'b0, lo_s7});
		end
	end

	// Stage 9: scaled product minus offset.
	always_ff @(posedge clk) begin
		if (adv[9]) begin
			temp_s9 <= temp_s8;
			diff_s9 <= DIFF_W'($signed(prod_s8[PROD_W-1:21])) - DIFF_W'(off_s8);
		end
	end

	// Stage 10: final shift. The shifted value spans 30 bits, so it is always
	// within the signed 32-bit limits and saturation never engages.
	always_ff @(posedge clk) begin
		if (adv[10]) begin
			pres_s10 <= OUT_W'($signed(diff_s9[DIFF_W-1:15]));
			temp_s10 <= OUT_W'(temp_s9);
		end
	end

endmodule

>>> tb/tb_pressure_temperature_compensation.sv
// Testbench for the pipelined second-order pressure and temperature compensation block.
module tb_pressure_temperature_compensation;
	import ptc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam logic [RAW_W-1:0] RAW_MAX = '1;
	localparam logic [CAL_W-1:0] CAL_MAX = '1;

	localparam longint TEMP_REF      = 2000;
	localparam longint TEMP_DEEP     = -1500;
	localparam int     SLOPE_SHIFT   = 23;
	localparam int     SENS_TC_SHIFT = 7;
	localparam int     OFF_TC_SHIFT  = 6;
	localparam int     T2_SHIFT      = 31;
	localparam int     RAW_SHIFT     = 21;
	localparam int     P_SHIFT       = 15;
	localparam longint OFF2_MUL      = 61;
	localparam int     OFF2_SHIFT    = 4;
	localparam longint DEEP_OFF_MUL  = 15;
	localparam longint DEEP_SENS_MUL = 8;
	localparam longint P_MAX         = 64'sd2147483647;
	localparam longint P_MIN         = -64'sd2147483648;

	localparam int IDLE_PCT       = 18;
	localparam int RANDOM_PHASES  = 7;
	localparam int PHASE_PAIRS    = 228;
	localparam int STEADY_PAIRS   = 200;
	localparam int HOLD_PAIRS     = 40;
	localparam int HOLD_CYCLES    = 80;
	localparam int TAIL_CYCLES    = 20;
	localparam int TIMEOUT_CYCLES = 200000;

	typedef struct {
		logic signed [OUT_W-1:0] pressure;
		logic signed [OUT_W-1:0] temperature;
	} comp_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [2*RAW_W-1:0]   s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [2*OUT_W-1:0]   m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CAL_W-1:0]     cfg_data = '0;

	cal_t         cal_model = CAL_RESET;
	comp_result_t pending_results[$];
	bit           steady = 1'b0;
	int           ready_hold = 0;
	int           n_fail = 0;
	int           n_pairs = 0;
	int           n_cold = 0;
	int           n_deep = 0;
	int           n_settings = 1;
	int           n_input_stalls = 0;

	pressure_temperature_compensation DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * TIMEOUT_CYCLES);
		$display("Some tests failed");
		$finish;
	end

	function automatic void compensate(input cal_t c, input logic [RAW_W-1:0] d1_raw,
			input logic [RAW_W-1:0] d2_raw, output logic signed [OUT_W-1:0] p_out,
			output logic signed [OUT_W-1:0] t_out, output bit cold, output bit deep);
		longint d1, d2, k_sens, k_off, k_sens_tc, k_off_tc, k_ref, k_slope;
		longint dt, temp, off, sens, t2, tm, tm2, off2, sens2, tp, tp2, p;
		d1 = longint'(d1_raw);
		d2 = longint'(d2_raw);
		k_sens = longint'(c.sensitivity);
		k_off = longint'(c.offset);
		k_sens_tc = longint'(c.sens_tempco);
		k_off_tc = longint'(c.offset_tempco);
		k_ref = longint'(c.ref_temp);
		k_slope = longint'(c.temp_slope);
		dt = d2 - k_ref * 256;
		temp = TEMP_REF + ((dt * k_slope) >>> SLOPE_SHIFT);
		off = k_off * 131072 + ((k_off_tc * dt) >>> OFF_TC_SHIFT);
		sens = k_sens * 65536 + ((k_sens_tc * dt) >>> SENS_TC_SHIFT);
		cold = temp < TEMP_REF;
		deep = 1'b0;
		if (cold) begin
			t2 = (dt * dt) >>> T2_SHIFT;
			tm = temp - TEMP_REF;
			tm2 = tm * tm;
			off2 = (OFF2_MUL * tm2) >>> OFF2_SHIFT;
			sens2 = 2 * tm2;
			if (temp < TEMP_DEEP) begin
				deep = 1'b1;
				tp = temp - TEMP_DEEP;
				tp2 = tp * tp;
				off2 += DEEP_OFF_MUL * tp2;
				sens2 += DEEP_SENS_MUL * tp2;
			end
			temp -= t2;
			off -= off2;
			sens -= sens2;
		end
		p = (((d1 * sens) >>> RAW_SHIFT) - off) >>> P_SHIFT;
		if (p > P_MAX) p = P_MAX;
		if (p < P_MIN) p = P_MIN;
		p_out = p[OUT_W-1:0];
		t_out = temp[OUT_W-1:0];
	endfunction

	function automatic logic [CAL_W-1:0] pick_cal_word();
		int r;
		r = $urandom_range(7);
		if (r == 0) return '0;
		if (r == 1) return CAL_MAX;
		return CAL_W'($urandom_range(32'hFFFF));
	endfunction

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			m_axis_tready <= 1'b0;
			ready_hold--;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : result_check
		comp_result_t want;
		logic signed [OUT_W-1:0] got_p, got_t;
		bit cold, deep;
		if (s_axis_tvalid && s_axis_tready) begin
			compensate(cal_model, s_axis_tdata[RAW_W-1:0], s_axis_tdata[2*RAW_W-1:RAW_W],
				want.pressure, want.temperature, cold, deep);
			pending_results.push_back(want);
			n_pairs++;
			n_cold += int'(cold);
			n_deep += int'(deep);
		end
		if (arst_n && s_axis_tvalid && !s_axis_tready) n_input_stalls++;
		if (m_axis_tvalid && m_axis_tready) begin
			got_p = m_axis_tdata[OUT_W-1:0];
			got_t = m_axis_tdata[2*OUT_W-1:OUT_W];
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: pressure_out %0d, temperature_out %0d",
					got_p, got_t);
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				if (got_p !== want.pressure) begin
					$error("pressure_out: expected %0d, got %0d", want.pressure, got_p);
					n_fail++;
				end
				if (got_t !== want.temperature) begin
					$error("temperature_out: expected %0d, got %0d", want.temperature, got_t);
					n_fail++;
				end
			end
		end
	end

	task automatic send_pair(input logic [RAW_W-1:0] raw_pressure,
			input logic [RAW_W-1:0] raw_temperature);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {raw_temperature, raw_pressure};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	task automatic send_random_pair();
		longint base, d2;
		logic [RAW_W-1:0] d1;
		base = longint'(cal_model.ref_temp) * 256;
		case ($urandom_range(3))
			0: d2 = longint'($urandom_range(RAW_MAX));
			1: d2 = base + longint'($urandom_range(2097152)) - 1048576;
			2: d2 = longint'($urandom_range(32'(base)));
			default: d2 = base + longint'($urandom_range(8192)) - 4096;
		endcase
		if (d2 < 0) d2 = 0;
		if (d2 > longint'(RAW_MAX)) d2 = longint'(RAW_MAX);
		case ($urandom_range(15))
			0: d1 = '0;
			1: d1 = RAW_MAX;
			default: d1 = RAW_W'($urandom_range(RAW_MAX));
		endcase
		send_pair(d1, d2[RAW_W-1:0]);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_SENSITIVITY:   cal_model.sensitivity = value;
			REG_OFFSET:        cal_model.offset = value;
			REG_SENS_TEMPCO:   cal_model.sens_tempco = value;
			REG_OFFSET_TEMPCO: cal_model.offset_tempco = value;
			REG_REF_TEMP:      cal_model.ref_temp = value;
			REG_TEMP_SLOPE:    cal_model.temp_slope = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_calibration(input cal_t c);
		write_reg(REG_SENSITIVITY, c.sensitivity);
		write_reg(REG_OFFSET, c.offset);
		write_reg(REG_SENS_TEMPCO, c.sens_tempco);
		write_reg(REG_OFFSET_TEMPCO, c.offset_tempco);
		write_reg(REG_REF_TEMP, c.ref_temp);
		write_reg(REG_TEMP_SLOPE, c.temp_slope);
		n_settings++;
	endtask

	// Temperature thresholds are found from the slope: the deep cold edge sits at -15.00 C.
	task automatic test_default_calibration();
		longint base, dt_deep;
		base = longint'(cal_model.ref_temp) * 256;
		dt_deep = -((3500 * 64'sd8388608) / longint'(cal_model.temp_slope));
		send_pair('0, '0);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(RAW_MAX, '0);
		send_pair('0, RAW_MAX);
		send_pair(24'h800000, base[RAW_W-1:0]);
		send_pair(24'h555555, RAW_W'(base - 1));
		send_pair(24'hAAAAAA, RAW_W'(base + dt_deep));
		send_pair(24'h7FFFFF, RAW_W'(base + dt_deep - 1));
		wait_drained();
	endtask

	task automatic test_register_extremes();
		cal_t c;
		c = '{default: '0};
		set_calibration(c);
		send_pair(RAW_MAX, '0);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair('0, 24'h123456);
		wait_drained();
		c = '{default: CAL_MAX};
		set_calibration(c);
		send_pair(RAW_MAX, '0);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(24'h654321, 24'hFFFF00);
		wait_drained();
		// Writes to the unused indexes must leave every calibration word alone.
		write_reg(REG_SPARE_A, 16'h0000);
		write_reg(REG_SPARE_B, 16'h5A5A);
		send_pair(RAW_MAX, 24'h000001);
		send_pair(24'h000001, 24'h800000);
		wait_drained();
	endtask

	task automatic test_random_calibrations();
		cal_t c;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0) begin
				c = CAL_RESET;
			end else begin
				c.sensitivity = pick_cal_word();
				c.offset = pick_cal_word();
				c.sens_tempco = pick_cal_word();
				c.offset_tempco = pick_cal_word();
				c.ref_temp = pick_cal_word();
				c.temp_slope = pick_cal_word();
			end
			set_calibration(c);
			for (int i = 0; i < PHASE_PAIRS; i++) send_random_pair();
			wait_drained();
		end
	endtask

	task automatic test_full_rate();
		steady = 1'b1;
		for (int i = 0; i < STEADY_PAIRS; i++) send_random_pair();
		wait_drained();
		steady = 1'b0;
	endtask

	task automatic test_output_stall();
		ready_hold = HOLD_CYCLES;
		steady = 1'b1;
		for (int i = 0; i < HOLD_PAIRS; i++) send_random_pair();
		wait_drained();
		steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_default_calibration();
		test_register_extremes();
		test_random_calibrations();
		test_full_rate();
		test_output_stall();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			n_fail++;
		end
		$display("Checked %0d pressure and temperature pairs over %0d calibration settings.",
			n_pairs, n_settings);
		$display("%0d pairs were below 20.00 C, %0d below -15.00 C; input stalled %0d cycles.",
			n_cold, n_deep, n_input_stalls);
		if (n_fail == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
